// File: rtl/bpra_pkg.sv
package bpra_pkg;

    localparam int unsigned MAP_WORDS_DEF      = 8192;
    localparam int unsigned PAGES_PER_WORD_DEF = 64;
    localparam int unsigned PAGE_SHIFT         = 12;
    localparam logic [63:0] BASE_RESET         = 64'hFFFF_FFFF_0000_0000;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CNT  = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_OOB      = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [19:0] page_count;
        logic [63:0] address;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] result_address;
    } t_rsp;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;        // capture request, reset cursor
        logic rd;          // issue read at cursor word
        logic eval;        // evaluate returned word
        logic wr_alloc;    // write one word of an allocation
        logic wr_free;     // write one word of a free
        logic step;        // advance cursor
        logic finish;      // latch result
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic is_free;
        logic is_large;
        logic bad_count;
        logic oob;
        logic hit;         // search found a place
        logic scan_end;    // cursor on last word
        logic wr_last;     // last word of write sweep
    } t_sts;

endpackage

// File: rtl/bpra_ram.sv
module bpra_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/bpra_datapath.sv
module bpra_datapath #(
    parameter int unsigned MAP_WORDS      = 8192,
    parameter int unsigned PAGES_PER_WORD = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bpra_pkg::t_req    i_req,
    input  logic [63:0]       i_base,
    input  bpra_pkg::t_cmd    i_cmd,
    input  logic              i_clr,
    output bpra_pkg::t_sts    o_sts,
    output bpra_pkg::t_rsp    o_rsp
);
    import bpra_pkg::*;

    localparam int unsigned AW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned BW  = $clog2(PAGES_PER_WORD);
    localparam int unsigned W   = PAGES_PER_WORD;
    localparam int unsigned CW  = AW + 1;
    localparam int unsigned TPW = AW + BW;
    localparam logic [63:0] TOTAL_BYTES = 64'(MAP_WORDS) << (BW + PAGE_SHIFT);

    logic [W-1:0]  rdata, wdata;
    logic [AW-1:0] raddr, waddr;
    logic          we;

    t_req          r_req;
    logic [AW-1:0] r_cur;          // scan / write cursor
    logic [CW-1:0] r_run;          // fully free words in a row
    logic [AW-1:0] r_start;        // first word of found range
    logic [BW-1:0] r_off;          // bit offset for small alloc
    logic [W-1:0]  r_mask;         // bits cleared in hit word
    logic          r_hit;
    t_rsp          r_rsp;

    // Free range, kept as page indices.
    logic [TPW:0]  r_fend;
    logic [TPW:0]  r_fcur;         // first page of current word

    logic [63:0]   offs;
    logic          big;
    logic [19:0]   cnt;
    logic [19:0]   whole;
    logic [BW-1:0] rest;
    logic [20:0]   needed;
    logic [W-1:0]  low_m;
    logic          small_hit;
    logic [BW-1:0] small_off;
    logic [W-1:0]  rest_m;
    logic [TPW:0]  first_pg;
    logic [TPW+20:0] end_sum;

    assign cnt    = r_req.page_count;
    assign big    = cnt > 20'(W);
    assign whole  = cnt >> BW;
    assign rest   = cnt[BW-1:0];
    assign needed = {1'b0, whole} + 21'(rest != '0);
    assign offs   = r_req.address - i_base;

    always_comb begin
        low_m = '0;
        for (int i = 0; i < W; i++) begin
            low_m[i] = (32'(i) < 32'(cnt));
        end
        rest_m = '0;
        for (int i = 0; i < W; i++) begin
            rest_m[i] = (i < int'(rest));
        end
    end

    // Lowest offset with cnt free bits; a window test per offset.
    always_comb begin
        small_hit = 1'b0;
        small_off = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if ((32'(i) + 32'(cnt) <= 32'(W)) &&
                (((rdata >> i) & low_m) == low_m)) begin
                small_hit = 1'b1;
                small_off = BW'(i);
            end
        end
    end

    assign first_pg = (TPW+1)'(offs >> PAGE_SHIFT);
    assign end_sum  = (TPW+21)'(first_pg) + (TPW+21)'(r_req.page_count);

    // Write port: sweep clear, allocation or free.
    logic [W-1:0] fmask;
    always_comb begin
        fmask = '0;
        for (int i = 0; i < W; i++) begin
            fmask[i] = ((r_fcur + (TPW+1)'(i)) < r_fend) &&
                       ((r_fcur + (TPW+1)'(i)) >= first_pg);
        end
    end

    always_comb begin
        we    = i_clr | i_cmd.wr_alloc | i_cmd.wr_free;
        waddr = r_cur;
        wdata = '1;
        if (i_cmd.wr_alloc) begin
            if (!big) begin
                wdata = rdata & ~r_mask;
            end else if (r_cur == r_start + AW'(whole) && rest != '0) begin
                wdata = ~rest_m;
            end else begin
                wdata = '0;
            end
        end else if (i_cmd.wr_free) begin
            wdata = rdata | fmask;
        end
    end

    assign raddr = r_cur;

    bpra_ram #(.WIDTH(W), .DEPTH(MAP_WORDS)) u_map (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_cur <= '0;
            r_run <= '0;
            r_hit <= 1'b0;
        end else if (i_clr) begin
            r_cur <= r_cur + AW'(1);
        end
        if (i_cmd.eval) begin
            if (!big) begin
                if (small_hit) begin
                    r_hit   <= 1'b1;
                    r_start <= r_cur;
                    r_off   <= small_off;
                    r_mask  <= low_m << small_off;
                end
            end else begin
                if (rdata == '1) begin
                    if (21'(r_run) + 21'd1 == needed) begin
                        r_hit   <= 1'b1;
                        r_start <= r_cur - AW'(needed - 21'd1);
                        r_off   <= '0;
                    end
                    r_run <= r_run + CW'(1);
                end else begin
                    r_run <= '0;
                end
            end
        end
        if (i_cmd.step) begin
            r_cur <= r_cur + AW'(1);
            r_fcur <= r_fcur + (TPW+1)'(W);
        end
        if (i_cmd.finish && r_hit && !r_req.operation) begin
            r_cur <= r_start;
        end
        if (i_cmd.finish && r_req.operation == OP_FREE) begin
            // Point cursor at the word of the first freed page.
            r_cur  <= AW'(first_pg >> BW);
            r_fcur <= (TPW+1)'((first_pg >> BW) << BW);
            r_fend <= (end_sum > (TPW+21)'(MAP_WORDS * W)) ?
                      (TPW+1)'(MAP_WORDS * W) : (TPW+1)'(end_sum);
        end
        if (i_cmd.finish) begin
            r_rsp.result_address <= '0;
            if (r_req.operation == OP_FREE) begin
                r_rsp.status <= (r_req.address < i_base || offs >= TOTAL_BYTES) ?
                                ST_OOB : ST_OK;
            end else if (cnt == '0) begin
                r_rsp.status <= ST_BAD_CNT;
            end else if (!r_hit) begin
                r_rsp.status <= ST_NO_SPACE;
            end else begin
                r_rsp.status <= ST_OK;
                r_rsp.result_address <= i_base +
                    ((64'(r_start) * 64'(W) + 64'(r_off)) << PAGE_SHIFT);
            end
        end
        // Start the clearing sweep from word 0.
        if (!i_rst_n) begin
            r_cur <= '0;
        end
    end

    logic [TPW:0] nxt_fcur;
    assign nxt_fcur = r_fcur + (TPW+1)'(W);

    always_comb begin
        o_sts.is_free   = r_req.operation == OP_FREE;
        o_sts.is_large  = big;
        o_sts.bad_count = cnt == '0;
        o_sts.oob       = r_req.address < i_base || offs >= TOTAL_BYTES;
        o_sts.hit       = r_hit;
        o_sts.scan_end  = r_cur == AW'(MAP_WORDS - 1);
        if (r_req.operation == OP_FREE) begin
            o_sts.wr_last = nxt_fcur >= r_fend || o_sts.scan_end;
        end else begin
            o_sts.wr_last = !big || r_cur == r_start + AW'(needed - 21'd1);
        end
    end

    assign o_rsp = r_rsp;
endmodule

// File: rtl/bpra_ctrl.sv
module bpra_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    input  bpra_pkg::t_sts i_sts,
    output bpra_pkg::t_cmd o_cmd,
    output logic           o_clr,
    output logic           o_clr_done
);
    import bpra_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECIDE, S_RD, S_EVAL, S_FIN,
        S_WRD, S_WEVAL, S_WR, S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_wrap;
    logic   r_rsp_valid;

    assign o_req_ready = r_state == S_IDLE && !r_rsp_valid;
    assign o_rsp_valid = r_rsp_valid;
    assign o_clr       = r_state == S_CLEAR;
    assign o_clr_done  = r_wrap;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.scan_end) n_state = S_IDLE;
            S_IDLE: begin
                if (i_req_valid && o_req_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.is_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = i_sts.oob ? S_RESP : S_WRD;
                end else if (i_sts.bad_count) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_RESP;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD:   n_state = S_EVAL;
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (i_sts.hit || i_sts.scan_end) begin
                    o_cmd.finish = 1'b1;
                    n_state = i_sts.hit ? S_WRD : S_RESP;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_WRD:   n_state = S_WEVAL;
            S_WEVAL: n_state = S_WR;
            S_WR: begin
                if (i_sts.is_free) o_cmd.wr_free = 1'b1;
                else               o_cmd.wr_alloc = 1'b1;
                if (i_sts.wr_last) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_WRD;
                end
            end
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rsp_valid <= 1'b0;
            r_wrap      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR && i_sts.scan_end) r_wrap <= 1'b1;
            if (r_state == S_RESP) begin
                r_rsp_valid <= 1'b1;
            end else if (r_rsp_valid && i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end
endmodule

// File: rtl/bitmap_page_range_allocator_core.sv
// First-fit page allocator over a free bitmap held in one RAM of MAP_WORDS
// words (set bit = free page). After reset a clearing pass writes every word
// to all-free, during which no request is taken; writes of region_base are
// taken at any time. An allocate scans words from word 0, each word read going
// through S_RD, S_EVAL and S_FIN (RAM read plus evaluation), then each word
// written goes through S_WRD, S_WEVAL and S_WR. A free touches only the words
// its page range covers, each through the same write states.
// One request is in flight at a time; a response beat waiting in the output
// register holds off the next request.
module bitmap_page_range_allocator_core #(
    parameter int unsigned MAP_WORDS      = bpra_pkg::MAP_WORDS_DEF,
    parameter int unsigned PAGES_PER_WORD = bpra_pkg::PAGES_PER_WORD_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [63:0]      i_cfg_data,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  bpra_pkg::t_req   i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output bpra_pkg::t_rsp   o_rsp
);
    import bpra_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    logic        clr, clr_done;
    logic [63:0] r_base;

    // Register writes are always accepted.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_valid) begin
            r_base <= i_cfg_data;
        end
    end

    bpra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_clr      (clr),
        .o_clr_done (clr_done)
    );

    bpra_datapath #(
        .MAP_WORDS     (MAP_WORDS),
        .PAGES_PER_WORD(PAGES_PER_WORD)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req),
        .i_base (r_base),
        .i_cmd  (cmd),
        .i_clr  (clr & ~clr_done),
        .o_sts  (sts),
        .o_rsp  (o_rsp)
    );
endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import bpra_pkg::*;

    localparam int unsigned N_WORDS    = MAP_WORDS_DEF;
    localparam int unsigned WORD_PAGES = PAGES_PER_WORD_DEF;
    localparam longint unsigned N_PAGES = longint'(N_WORDS) * WORD_PAGES;
    localparam logic [63:0] REGION_BYTES = 64'(N_PAGES) << PAGE_SHIFT;
    localparam int unsigned CYCLE_LIMIT = 20_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [63:0] i_cfg_data;
    logic        i_req_valid;
    logic        o_req_ready;
    t_req        i_req;
    logic        o_rsp_valid;
    logic        i_rsp_ready;
    t_rsp        o_rsp;

    bitmap_page_range_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    // Shadow copy of the free bitmap and the base register.
    logic [63:0] shadow_map [N_WORDS];
    logic [63:0] shadow_base;

    t_req pending_reqs[$];   // beats still to be offered
    t_rsp expected_rsps[$];  // responses owed by the block, oldest first
    int   errors;
    logic req_taken;
    logic long_hold;         // ask the receiver for one long hold-off
    logic hold_send;
    int   send_gap;
    int   recv_gap;
    int   cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int rand_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] low_mask(int unsigned n);
        if (n >= 64) return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    // First-fit allocate and range free, applied to the shadow map.
    function automatic t_rsp predict_alloc_free(t_req r);
        t_rsp        rsp;
        logic [63:0] bits, mask, page, offset;
        longint unsigned lo_pg, hi_pg;
        int unsigned cnt, whole, rest, needed, run, start;
        bit found;
        rsp = '0;
        cnt = r.page_count;
        found = 0;
        page = '0;
        if (r.operation == OP_ALLOC) begin
            if (cnt == 0) begin
                rsp.status = ST_BAD_CNT;
            end else if (cnt <= WORD_PAGES) begin
                mask = low_mask(cnt);
                for (int w = 0; w < N_WORDS && !found; w++) begin
                    bits = shadow_map[w];
                    for (int i = 0; i + cnt <= WORD_PAGES && !found; i++) begin
                        if ((bits & (mask << i)) == (mask << i)) begin
                            shadow_map[w] = bits & ~(mask << i);
                            page = 64'(w) * WORD_PAGES + i;
                            found = 1;
                        end
                    end
                end
            end else begin
                whole = cnt / WORD_PAGES;
                rest = cnt % WORD_PAGES;
                needed = whole + (rest != 0 ? 1 : 0);
                run = 0;
                if (needed <= N_WORDS) begin
                    for (int w = 0; w < N_WORDS && !found; w++) begin
                        run = (shadow_map[w] == '1) ? run + 1 : 0;
                        if (run == needed) begin
                            start = w + 1 - needed;
                            for (int k = 0; k < whole; k++) shadow_map[start + k] = '0;
                            if (rest != 0) shadow_map[w] = ~low_mask(rest);
                            page = 64'(start) * WORD_PAGES;
                            found = 1;
                        end
                    end
                end
            end
            if (cnt != 0) begin
                if (found) rsp.result_address = shadow_base + (page << PAGE_SHIFT);
                else rsp.status = ST_NO_SPACE;
            end
        end else begin
            offset = r.address - shadow_base;
            if (r.address < shadow_base || offset >= REGION_BYTES) begin
                rsp.status = ST_OOB;
            end else begin
                lo_pg = offset >> PAGE_SHIFT;
                hi_pg = lo_pg + cnt;
                if (hi_pg > N_PAGES) hi_pg = N_PAGES;
                for (longint unsigned p = lo_pg; p < hi_pg; p++)
                    shadow_map[p / WORD_PAGES][p % WORD_PAGES] = 1'b1;
            end
        end
        return rsp;
    endfunction

    function automatic t_req make_req(logic op, int unsigned cnt, logic [63:0] addr);
        t_req r;
        r.operation = op;
        r.page_count = 20'(cnt);
        r.address = addr;
        return r;
    endfunction

    // Mostly small allocations and in-region frees, with some noise.
    function automatic t_req rand_req(logic [63:0] base);
        int unsigned pick, cnt;
        logic [63:0] addr;
        addr = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) cnt = 0;
            else if (pick < 75) cnt = $urandom_range(1, 64);
            else if (pick < 95) cnt = $urandom_range(65, 640);
            else cnt = $urandom_range(641, 4096);
            return make_req(OP_ALLOC, cnt, addr);
        end
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 524288)
                                          : $urandom_range(0, 200);
        if ($urandom_range(0, 4) != 0)
            addr = base + (64'($urandom_range(0, 4095)) << PAGE_SHIFT)
                 + 64'($urandom_range(0, 4095));
        return make_req(OP_FREE, cnt, addr);
    endfunction

    // Driver: present beats at the falling edge, hold until taken.
    always @(negedge i_clk) begin
        logic busy, vld_n;
        busy = i_req_valid && !req_taken;
        vld_n = busy;
        if (!busy) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_reqs.size() > 0 && !hold_send) begin
                i_req <= pending_reqs.pop_front();
                vld_n = 1'b1;
                send_gap = rand_gap();
            end
        end
        i_req_valid <= vld_n;
    end

    // Receiver stalls; one long hold-off on request.
    always @(negedge i_clk) begin
        if (long_hold) begin
            long_hold <= 1'b0;
            recv_gap = 400;
        end
        if (recv_gap > 0) begin
            recv_gap--;
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= 1'b1;
            recv_gap = rand_gap();
        end
    end

    // Monitor: retire responses first, then predict the newly taken request.
    always @(posedge i_clk) begin
        t_rsp want;
        req_taken <= i_req_valid && o_req_ready;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (expected_rsps.size() == 0) begin
                $display("%0t: response %h with none expected", $time, o_rsp);
                errors++;
            end else begin
                want = expected_rsps.pop_front();
                if (o_rsp.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_rsp.status);
                    errors++;
                end
                if (o_rsp.result_address !== want.result_address) begin
                    $display("%0t: result_address expected %h actual %h",
                             $time, want.result_address, o_rsp.result_address);
                    errors++;
                end
            end
        end
        if (i_rst_n && i_req_valid && o_req_ready)
            expected_rsps.push_back(predict_alloc_free(i_req));
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_base(logic [63:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_base = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every beat is out and every response is back.
    task automatic drain();
        while (pending_reqs.size() > 0 || i_req_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic push_random(int n);
        repeat (n) pending_reqs.push_back(rand_req(shadow_base));
    endtask

    initial begin
        logic [63:0] b;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_req_valid = 1'b0;
        i_req = '0;
        i_rsp_ready = 1'b0;
        req_taken = 1'b0;
        long_hold = 1'b0;
        hold_send = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        errors = 0;
        cycles = 0;
        shadow_base = BASE_RESET;
        for (int w = 0; w < N_WORDS; w++) shadow_map[w] = '1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at the reset base.
        b = BASE_RESET;
        pending_reqs.push_back(make_req(OP_ALLOC, 0, '1));
        pending_reqs.push_back(make_req(OP_ALLOC, 1, '0));
        pending_reqs.push_back(make_req(OP_ALLOC, 64, '0));
        pending_reqs.push_back(make_req(OP_ALLOC, 63, '0));
        pending_reqs.push_back(make_req(OP_ALLOC, 65, '0));
        pending_reqs.push_back(make_req(OP_ALLOC, 128, '0));
        pending_reqs.push_back(make_req(OP_FREE, 1, b));
        pending_reqs.push_back(make_req(OP_FREE, 2, b + 64'd4096 + 64'd123));
        pending_reqs.push_back(make_req(OP_FREE, 0, b + 64'd8192));
        pending_reqs.push_back(make_req(OP_FREE, 5, b + REGION_BYTES - 64'd4096));
        pending_reqs.push_back(make_req(OP_FREE, 3, b - 64'd1));
        pending_reqs.push_back(make_req(OP_FREE, 3, b + REGION_BYTES));
        pending_reqs.push_back(make_req(OP_FREE, 1, '1));
        pending_reqs.push_back(make_req(OP_FREE, 10, b + 64'h10_0000));
        pending_reqs.push_back(make_req(OP_FREE, 524288, b));
        pending_reqs.push_back(make_req(OP_ALLOC, 524288, '0));
        pending_reqs.push_back(make_req(OP_ALLOC, 1, '0));
        pending_reqs.push_back(make_req(OP_ALLOC, 600000 % 524288 + 1, '0));
        pending_reqs.push_back(make_req(OP_FREE, 524288, b));
        pending_reqs.push_back(make_req(OP_ALLOC, 2, '0));
        drain();

        // Base at zero; the receiver holds off while beats keep coming.
        write_base('0);
        push_random(35);
        long_hold <= 1'b1;
        drain();

        // Base at all ones: only the top address is in range, sums wrap.
        write_base('1);
        pending_reqs.push_back(make_req(OP_FREE, 4, '1));
        pending_reqs.push_back(make_req(OP_FREE, 4, '0));
        pending_reqs.push_back(make_req(OP_ALLOC, 3, '0));
        pending_reqs.push_back(make_req(OP_ALLOC, 700, '0));
        drain();

        // Random page-aligned base; hold the sender until all is back.
        write_base({$urandom, $urandom} & ~64'hFFF);
        push_random(15);
        hold_send = 1'b1;
        while (expected_rsps.size() > 0 || i_req_valid) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        hold_send = 1'b0;
        push_random(15);
        drain();

        write_base(64'hFFFF_FFFF_8000_0000);
        push_random(30);
        drain();
        repeat (50) @(posedge i_clk);

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
